FILE: rtl/pfa_pkg.sv
// Package for the partition fit allocator.
// Holds the request and result payload types, the controller state type and shared codes.
// No dependencies.
package pfa_pkg;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  block_index;
		logic [15:0] size_value;
		logic [7:0]  request_id;
	} pfa_in_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_block;
		logic [15:0] free_after;
		logic [7:0]  request_tag;
	} pfa_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} pfa_state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic commit;
	} pfa_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic slot_free;
	} pfa_stat_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	localparam logic CFG_FIT_MODE    = 1'b0;
	localparam logic CFG_BLOCK_COUNT = 1'b1;

	localparam int          CFG_DATA_W        = 5;
	localparam logic [4:0]  BLOCK_COUNT_RESET = 5'd16;

endpackage

FILE: rtl/pfa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/pfa_ctrl.sv
// Controller state machine of the partition fit allocator.
// Sequences capture, scan and commit; depends on pfa_pkg.
module pfa_ctrl import pfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pfa_stat_t stat,
	output pfa_cmd_t  cmd
);

	pfa_state_t state_q;
	pfa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (stat.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.scan    = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = stat.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/pfa_datapath.sv
// Datapath of the partition fit allocator: capacity store, scan compare and result register.
// Depends on pfa_pkg and pfa_ram.
module pfa_datapath import pfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfa_cmd_t              cmd,
	output pfa_stat_t             stat,
	input  pfa_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pfa_out_t              out_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int WW = (SIZE_BITS > 16) ? SIZE_BITS : 16;

	logic                 fit_mode_q;
	logic [4:0]           block_count_q;
	pfa_in_t              item_q;
	logic [CW-1:0]        live_q;
	logic [CW-1:0]        iss_q;
	logic                 cmp_vld_s1;
	logic                 ent_vld_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] pick_cap_q;
	logic [NUM_BLOCKS-1:0] valid_q;
	logic                 out_valid_q;
	pfa_out_t             res_q;

	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] cap_s1;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 issue;
	logic                 is_load;
	logic                 load_hit;
	logic [SIZE_BITS-1:0] new_cap;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [SIZE_BITS-1:0] wr_data;
	logic [CW-1:0]        live_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_FIRST;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[4:0];
				default:         fit_mode_q    <= fit_mode_q;
			endcase
		end
	end

	assign live_d = (int'(block_count_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(block_count_q);

	assign is_load  = (item_q.opcode == OP_LOAD);
	assign load_hit = (int'(item_q.block_index) < NUM_BLOCKS);
	assign issue    = cmd.scan && !is_load && (iss_q < live_q);

	assign cap_s1 = ent_vld_s1 ? rd_data : '0;
	assign fits   = (WW'(cap_s1) >= WW'(item_q.size_value));
	assign better = !found_q || ((fit_mode_q == FIT_BEST) && (cap_s1 < pick_cap_q));
	assign take   = cmd.scan && cmp_vld_s1 && fits && better;

	assign stat.scan_done = is_load || ((fit_mode_q == FIT_FIRST) && found_q) ||
		((iss_q == live_q) && !cmp_vld_s1);
	assign stat.slot_free = !out_valid_q || out_ready;

	assign new_cap = pick_cap_q - SIZE_BITS'(item_q.size_value);
	assign wr_en   = cmd.commit && (is_load ? load_hit : found_q);
	assign wr_addr = is_load ? AW'(item_q.block_index) : pick_q;
	assign wr_data = is_load ? SIZE_BITS'(item_q.size_value) : new_cap;

	pfa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(NUM_BLOCKS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(iss_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (cmd.capture) begin
			iss_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (cmd.scan) begin
			cmp_vld_s1 <= issue;
			if (issue) iss_q <= iss_q + 1'b1;
			if (take) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
			live_q <= live_d;
		end
		if (issue) begin
			cmp_idx_s1 <= iss_q[AW-1:0];
			ent_vld_s1 <= valid_q[iss_q[AW-1:0]];
		end
		if (take) begin
			pick_q     <= cmp_idx_s1;
			pick_cap_q <= cap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.request_tag <= item_q.request_id;
			if (is_load) begin
				res_q.granted      <= 1'b0;
				res_q.chosen_block <= item_q.block_index;
				res_q.free_after   <= load_hit ? 16'(SIZE_BITS'(item_q.size_value)) : '0;
			end else if (found_q) begin
				res_q.granted      <= 1'b1;
				res_q.chosen_block <= 4'(pick_q);
				res_q.free_after   <= 16'(new_cap);
			end else begin
				res_q.granted      <= 1'b0;
				res_q.chosen_block <= '0;
				res_q.free_after   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

FILE: rtl/partition_fit_allocator.sv
// Top level of the partition fit allocator.
// Joins pfa_ctrl and pfa_datapath; depends on pfa_pkg.
//
// The block keeps one free capacity per partition in a small RAM and handles one request at a
// time. A load goes from acceptance through the scan and commit states to a registered result.
// An allocate scans the partitions in use through the single RAM read port, one partition a
// cycle; in first fit the scan stops at the first partition that fits. A commit waits while a
// stalled result still holds the result register. Capacities read as zero after reset through
// per-partition valid flags, so no clearing pass is needed. The controller returns to idle as
// the result is registered, so the next request can be accepted even while that result waits.
module partition_fit_allocator import pfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pfa_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pfa_out_t              out_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pfa_cmd_t  cmd;
	pfa_stat_t stat;

	pfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	pfa_datapath #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("A second request was accepted while one was in flight.");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("A result appeared without a request in flight.");

	a_commit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !in_ready) |=> (out_valid && $stable(out_data)))
		else $error("A pending result was overwritten.");

endmodule

FILE: sim/partition_fit_allocator_tb.sv
// Self-checking testbench for partition_fit_allocator: directed and random load and allocate
// requests under random idling on both channels, checked against a built-in allocation model.
// Depends on pfa_pkg and the partition_fit_allocator RTL.
module partition_fit_allocator_tb;
	import pfa_pkg::*;

	localparam int NUM_BLOCKS   = 16;
	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_ready;
	pfa_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	pfa_out_t              out_data;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [15:0] free_cap [NUM_BLOCKS];
	logic        fit_mode;
	logic [4:0]  block_count;
	pfa_out_t    grant_queue [$];
	int          error_count = 0;
	int          quiet_left = 0;
	int          hold_req = 0;

	always #CLK_HALF clk = ~clk;

	partition_fit_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic pfa_out_t compute_grant(input pfa_in_t req);
		pfa_out_t res;
		int       live;
		bit       found;
		int       pick;
		res = '0;
		res.request_tag = req.request_id;
		found = 1'b0;
		pick = 0;
		if (req.opcode == OP_LOAD) begin
			free_cap[req.block_index] = req.size_value;
			res.chosen_block = req.block_index;
			res.free_after = req.size_value;
		end else begin
			live = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : block_count;
			for (int j = 0; j < live; j++) begin
				if (free_cap[j] >= req.size_value && (!found ||
						(fit_mode == FIT_BEST && free_cap[j] < free_cap[pick]))) begin
					pick = j;
					found = 1'b1;
				end
			end
			if (found) begin
				free_cap[pick] = free_cap[pick] - req.size_value;
				res.granted = 1'b1;
				res.chosen_block = pick[3:0];
				res.free_after = free_cap[pick];
			end
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_left > 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pfa_in_t random_request();
		pfa_in_t req;
		int      r;
		int      live;
		req.opcode = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_ALLOC;
		req.block_index = 4'($urandom_range(0, 15));
		req.request_id = 8'($urandom_range(0, 255));
		live = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : block_count;
		r = $urandom_range(0, 99);
		if (req.opcode == OP_LOAD) begin
			if (live > 0 && r < 70)
				req.block_index = 4'($urandom_range(0, live - 1));
			r = $urandom_range(0, 99);
			if (r < 10)
				req.size_value = 16'h0000;
			else if (r < 20)
				req.size_value = 16'hFFFF;
			else if (r < 60)
				req.size_value = 16'($urandom_range(1, 2000));
			else
				req.size_value = 16'($urandom);
		end else begin
			if (r < 10)
				req.size_value = 16'h0000;
			else if (r < 40)
				req.size_value = free_cap[$urandom_range(0, NUM_BLOCKS - 1)];
			else if (r < 80)
				req.size_value = 16'($urandom_range(1, 1000));
			else if (r < 92)
				req.size_value = 16'($urandom);
			else
				req.size_value = 16'hFFFF;
		end
		return req;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	task automatic send_request(input pfa_in_t req, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		grant_queue.push_back(compute_grant(req));
		if (quiet_left > 0)
			quiet_left--;
	endtask

	task automatic issue_item(input logic op, input logic [3:0] idx, input logic [15:0] size,
			input logic [7:0] tag);
		pfa_in_t req;
		req.opcode = op;
		req.block_index = idx;
		req.size_value = size;
		req.request_id = tag;
		send_request(req, pick_gap());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (grant_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_FIT_MODE)
			fit_mode = value[0];
		else
			block_count = value;
	endtask

	task automatic test_reset_state();
		issue_item(OP_ALLOC, 4'd0, 16'd0, 8'h00);
		issue_item(OP_ALLOC, 4'd15, 16'd1, 8'hFF);
	endtask

	task automatic test_first_fit();
		issue_item(OP_LOAD, 4'd0, 16'd100, 8'd1);
		issue_item(OP_LOAD, 4'd3, 16'd50, 8'd2);
		issue_item(OP_LOAD, 4'd7, 16'd200, 8'd3);
		issue_item(OP_LOAD, 4'd15, 16'hFFFF, 8'd4);
		issue_item(OP_ALLOC, 4'd9, 16'd60, 8'd5);
		issue_item(OP_ALLOC, 4'd0, 16'd45, 8'd6);
		issue_item(OP_ALLOC, 4'd0, 16'hFFFF, 8'd7);
		issue_item(OP_ALLOC, 4'd0, 16'd200, 8'd8);
		issue_item(OP_ALLOC, 4'd0, 16'd50, 8'd9);
	endtask

	task automatic test_best_fit();
		wait_idle();
		write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
		issue_item(OP_LOAD, 4'd1, 16'd300, 8'd10);
		issue_item(OP_LOAD, 4'd2, 16'd120, 8'd11);
		issue_item(OP_LOAD, 4'd4, 16'd120, 8'd12);
		issue_item(OP_LOAD, 4'd9, 16'd500, 8'd13);
		issue_item(OP_ALLOC, 4'd0, 16'd100, 8'd14);
		issue_item(OP_ALLOC, 4'd0, 16'd100, 8'd15);
		issue_item(OP_ALLOC, 4'd0, 16'd250, 8'd16);
		issue_item(OP_ALLOC, 4'd0, 16'd0, 8'd17);
	endtask

	task automatic test_partition_count();
		wait_idle();
		write_reg(CFG_BLOCK_COUNT, 5'd0);
		issue_item(OP_ALLOC, 4'd0, 16'd0, 8'd18);
		wait_idle();
		write_reg(CFG_BLOCK_COUNT, 5'd4);
		issue_item(OP_LOAD, 4'd10, 16'd700, 8'd19);
		issue_item(OP_ALLOC, 4'd0, 16'd600, 8'd20);
		wait_idle();
		write_reg(CFG_BLOCK_COUNT, 5'd31);
		issue_item(OP_ALLOC, 4'd0, 16'd600, 8'd21);
		wait_idle();
		write_reg(CFG_BLOCK_COUNT, 5'd1);
		issue_item(OP_ALLOC, 4'd0, 16'd30, 8'd22);
	endtask

	task automatic test_random(input logic mode, input logic [4:0] count, input int n);
		wait_idle();
		write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_BLOCK_COUNT, count);
		repeat (n) begin
			if ($urandom_range(0, 49) == 0)
				quiet_left = $urandom_range(20, 60);
			send_request(random_request(), pick_gap());
		end
		wait_idle();
	endtask

	task automatic test_backpressure(input int n);
		wait_idle();
		write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
		write_reg(CFG_BLOCK_COUNT, BLOCK_COUNT_RESET);
		hold_req = HOLD_CYCLES;
		repeat (n) send_request(random_request(), 0);
		wait_idle();
	endtask

	initial begin : receiver
		int stall_left;
		int r;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (quiet_left > 0) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		pfa_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_queue.size() == 0) begin
				report_mismatch("unexpected result tag", out_data.request_tag, -1);
			end else begin
				want = grant_queue.pop_front();
				if (out_data.granted !== want.granted)
					report_mismatch("granted", out_data.granted, want.granted);
				if (out_data.chosen_block !== want.chosen_block)
					report_mismatch("chosen_block", out_data.chosen_block, want.chosen_block);
				if (out_data.free_after !== want.free_after)
					report_mismatch("free_after", out_data.free_after, want.free_after);
				if (out_data.request_tag !== want.request_tag)
					report_mismatch("request_tag", out_data.request_tag, want.request_tag);
			end
		end
	end

	initial begin
		#12_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIT_MODE;
		cfg_data = '0;
		fit_mode = FIT_FIRST;
		block_count = BLOCK_COUNT_RESET;
		foreach (free_cap[i])
			free_cap[i] = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_first_fit();
		test_best_fit();
		test_partition_count();
		test_random(FIT_FIRST, 5'd16, 400);
		test_random(FIT_BEST, 5'd16, 400);
		test_random(FIT_FIRST, 5'd5, 250);
		test_random(FIT_BEST, 5'd1, 150);
		test_random(FIT_BEST, 5'($urandom_range(17, 31)), 200);
		test_random(FIT_FIRST, 5'd0, 40);
		test_random(FIT_FIRST, 5'($urandom_range(2, 15)), 200);
		test_backpressure(300);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_ctrl.sv
rtl/pfa_datapath.sv
rtl/partition_fit_allocator.sv
sim/partition_fit_allocator_tb.sv
